FILE: rtl/core/mp3lt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3lt_pkg
// Types, codes and the frame header test shared by the leading tag skipper
// and frame sync finder.
// ----------------------------------------------------------------------------
package mp3lt_pkg;

  localparam int unsigned PosW   = 29;
  localparam int unsigned LimitW = 16;
  localparam logic [LimitW-1:0] SearchLimitRst = 16'd2048;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] frame_offset;
    logic            id3_seen;
    logic            album_seen;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_SYNC      = 2'd0,
    ST_NO_SYNC   = 2'd1,
    ST_EARLY_END = 2'd2,
    ST_ALB_SHORT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEAD     = 3'd1,
    PH_SKIP_ID3 = 3'd2,
    PH_PROBE    = 3'd3,
    PH_ALBLEN   = 3'd4,
    PH_SKIP_ALB = 3'd5,
    PH_SEARCH   = 3'd6
  } phase_e;

  // Bit n set: layer II with that bitrate index forbids channel mode n.
  localparam logic [3:0] Layer2Bad [16] = '{
    4'd0, 4'd7, 4'd7, 4'd7, 4'd0, 4'd7, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };

  function automatic logic frame_header_ok(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
    logic ok;
    logic [3:0] bad;
    begin
      bad = Layer2Bad[b2[7:4]];
      ok  = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (b1[4:3] != 2'b01) &&
            (b1[2:1] != 2'b00) && (b2[7:4] != 4'hF) && (b2[3:2] != 2'b11) &&
            (b3[1:0] != 2'b10);
      if ((b1[4:3] == 2'b11) && (b1[2:1] == 2'b10) && bad[b3[7:6]]) begin
        ok = 1'b0;
      end
      return ok;
    end
  endfunction

endpackage

FILE: rtl/core/mp3lt_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3lt_parser
// Per-byte parse state: tag header capture, skips, album header probe and the
// sliding-window frame header search. Produces at most one result per byte.
// ----------------------------------------------------------------------------
module mp3lt_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               item_valid_i,
  input  mp3lt_pkg::in_item_t                item_i,
  input  logic [mp3lt_pkg::LimitW-1:0]       search_limit_i,
  output logic                               res_valid_o,
  output mp3lt_pkg::out_item_t               res_o
);
  import mp3lt_pkg::*;

  phase_e            phase_q, phase_d, ph_cur;
  logic [PosW-1:0]   pos_q, pos_cur, pos_p1;
  logic [23:0]       rec_q, rec_cur;
  logic [PosW-1:0]   skp_q, skp_cur, skp_d;
  logic [LimitW-1:0] tries_q, tries_cur, tries_d;
  logic [1:0]        flags_q, flags_cur, flags_d;
  logic [7:0]        b0, b1, b2, cur;
  logic [27:0]       tag_sz;
  logic [15:0]       alb_len;
  logic              active, done;
  status_e           st;
  logic [PosW-1:0]   off;

  // A start-of-file byte sees a freshly cleared state.
  always_comb begin
    ph_cur    = item_i.start_of_file ? PH_HEAD : phase_q;
    pos_cur   = item_i.start_of_file ? '0 : pos_q;
    rec_cur   = item_i.start_of_file ? '0 : rec_q;
    skp_cur   = item_i.start_of_file ? '0 : skp_q;
    tries_cur = item_i.start_of_file ? '0 : tries_q;
    flags_cur = item_i.start_of_file ? '0 : flags_q;
    active    = (ph_cur != PH_IDLE);
    b0        = rec_cur[23:16];
    b1        = rec_cur[15:8];
    b2        = rec_cur[7:0];
    cur       = item_i.data_byte;
    pos_p1    = pos_cur + PosW'(1);
    tag_sz    = {b0[6:0], b1[6:0], b2[6:0], cur[6:0]};
    alb_len   = {cur, b2};
  end

  // Next state.
  always_comb begin
    phase_d = ph_cur;
    skp_d   = skp_cur;
    tries_d = tries_cur;
    flags_d = flags_cur;
    done    = 1'b0;
    st      = ST_EARLY_END;
    off     = '0;
    case (ph_cur)
      PH_HEAD: begin
        if (pos_cur == PosW'(3)) begin
          if (!(b0 == 8'h49 && b1 == 8'h44 && b2 == 8'h33)) begin
            phase_d = PH_PROBE;
            skp_d   = '0;
          end
        end else if (pos_cur == PosW'(9)) begin
          flags_d[0] = 1'b1;
          skp_d      = PosW'(tag_sz) + PosW'(10);
          phase_d    = (tag_sz == '0) ? PH_PROBE : PH_SKIP_ID3;
        end
      end
      PH_SKIP_ID3: begin
        if (pos_p1 == skp_cur) phase_d = PH_PROBE;
      end
      PH_ALBLEN: begin
        if ({1'b0, pos_cur} == {1'b0, skp_cur} + (PosW+1)'(5)) begin
          if (alb_len < 16'd6) begin
            done = 1'b1;
            st   = ST_ALB_SHORT;
          end else begin
            flags_d[1] = 1'b1;
            skp_d      = skp_cur + PosW'(alb_len);
            phase_d    = (alb_len == 16'd6) ? PH_SEARCH : PH_SKIP_ALB;
          end
        end
      end
      PH_SKIP_ALB: begin
        if (pos_p1 == skp_cur) phase_d = PH_SEARCH;
      end
      default: ;
    endcase

    // The four bytes after any ID3 tag decide between album header and search.
    if (!done && phase_d == PH_PROBE &&
        {1'b0, pos_cur} == {1'b0, skp_d} + (PosW+1)'(3)) begin
      phase_d = (b0 == 8'h41 && b1 == 8'h69 && b2 == 8'h44 && cur == 8'h01) ?
                PH_ALBLEN : PH_SEARCH;
    end

    if (!done && phase_d == PH_SEARCH &&
        {1'b0, pos_cur} >= {1'b0, skp_d} + (PosW+1)'(3)) begin
      if (frame_header_ok(b0, b1, b2, cur)) begin
        done = 1'b1;
        st   = ST_SYNC;
        off  = pos_cur - PosW'(3);
      end else begin
        tries_d = tries_cur + LimitW'(1);
        if (tries_d >= search_limit_i) begin
          done = 1'b1;
          st   = ST_NO_SYNC;
        end
      end
    end

    if (!done && item_i.end_of_file) begin
      done = 1'b1;
      st   = ST_EARLY_END;
    end

    if (done) phase_d = PH_IDLE;
  end

  // Outputs.
  always_comb begin
    res_valid_o        = item_valid_i && active && done;
    res_o.status       = st;
    res_o.frame_offset = (st == ST_SYNC) ? off : '0;
    res_o.id3_seen     = flags_d[0];
    res_o.album_seen   = flags_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      rec_q   <= '0;
      skp_q   <= '0;
      tries_q <= '0;
      flags_q <= '0;
    end else if (item_valid_i && active) begin
      phase_q <= phase_d;
      pos_q   <= pos_p1;
      rec_q   <= {rec_cur[15:0], cur};
      skp_q   <= skp_d;
      tries_q <= tries_d;
      flags_q <= flags_d;
    end
  end

endmodule

FILE: rtl/core/mp3lt_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3lt_out_buf
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module mp3lt_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  mp3lt_pkg::out_item_t item_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mp3lt_pkg::out_item_t item_o
);
  import mp3lt_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && load_i) item_q <= item_i;
  end

endmodule

FILE: rtl/core/mp3_leading_tag_skip_and_sync_find_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_leading_tag_skip_and_sync_find_core
// Skips a leading ID3v2 tag and album ID header, then finds the first MPEG
// audio frame header within the configured number of start positions.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle for as long as results are taken:
// a byte is registered on acceptance and, once the result register has room,
// parsed by a single pass through the parse logic; any result it ends with is
// loaded into the result register at the end of the cycle it is parsed in.
// Every file, once started with start_of_file, yields at most one result, and
// exactly one if it ends with end_of_file; bytes outside a file are dropped.
// search_limit may be written at any time the block is idle and resets to 2048.
module mp3_leading_tag_skip_and_sync_find_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mp3lt_pkg::LimitW-1:0]       cfg_search_limit_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  mp3lt_pkg::in_item_t                in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output mp3lt_pkg::out_item_t               out_item_o
);
  import mp3lt_pkg::*;

  logic              in_valid_q;
  in_item_t          in_item_q;
  logic [LimitW-1:0] limit_q;
  logic              room, adv, res_valid;
  out_item_t         res;

  assign cfg_ready_o = 1'b1;
  assign adv         = in_valid_q && room;
  assign in_ready_o  = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= SearchLimitRst;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_search_limit_i;
      if (in_ready_o) in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_item_i;
  end

  mp3lt_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (adv),
    .item_i         (in_item_q),
    .search_limit_i (limit_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  mp3lt_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .item_i  (res),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

endmodule

FILE: rtl/core/mp3lt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3lt_checker
// Port-level checks for the tag skipper and sync finder.
// ----------------------------------------------------------------------------
module mp3lt_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_o,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  mp3lt_pkg::out_item_t               out_item_o
);
  import mp3lt_pkg::*;

  // A stalled result request holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // With the result register empty the input side never stalls.
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_SYNC |-> out_item_o.frame_offset == '0)
    else $error("frame offset set without sync");

  a_short_album: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_ALB_SHORT |-> !out_item_o.album_seen)
    else $error("album flagged on a short album header");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration request not taken");

endmodule

bind mp3_leading_tag_skip_and_sync_find_core mp3lt_checker u_mp3lt_checker (.*);

FILE: tb/mp3_leading_tag_skip_and_sync_find_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3_leading_tag_skip_and_sync_find_core_tb
// Self-checking bench for the leading tag skipper and frame sync finder.
// Files are streamed in one byte per request. They come with and without ID3
// tags and album headers, and some are cut short, restarted or pure noise.
// A scoreboard keeps its own model of the parse and compares every result,
// field by field, with the oldest one it predicted.
// ----------------------------------------------------------------------------
module mp3_leading_tag_skip_and_sync_find_core_tb;
  import mp3lt_pkg::*;

  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned MinPhases   = 4;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned TimeoutNs   = 2_400_000;

  class result_scoreboard;
    logic [LimitW-1:0] limit = SearchLimitRst;
    phase_e            phase = PH_IDLE;
    logic [28:0]       pos = '0;
    logic [23:0]       recent = '0;
    logic [27:0]       tag_size = '0;
    logic [28:0]       skip_end = '0;
    logic [15:0]       alb_len = '0;
    logic [15:0]       tries = '0;
    logic [1:0]        flags = '0;
    out_item_t         expected[$];
    int unsigned       live_bytes;
    int unsigned       files_started;
    int unsigned       results_checked;
    int unsigned       status_hits[4];
    int unsigned       errors;

    function int unsigned pending();
      return expected.size();
    endfunction

    function bit header_valid(logic [7:0] h0, logic [7:0] h1, logic [7:0] h2, logic [7:0] h3);
      logic [3:0] bad_modes;
      case (h2[7:4])
        4'd1, 4'd2, 4'd3, 4'd5:          bad_modes = 4'b0111;
        4'd11, 4'd12, 4'd13, 4'd14, 4'd15: bad_modes = 4'b1000;
        default:                         bad_modes = 4'b0000;
      endcase
      if (h0 != 8'hFF || h1[7:5] != 3'b111) return 1'b0;
      if (h1[4:3] == 2'b01 || h1[2:1] == 2'b00) return 1'b0;
      if (h2[7:4] == 4'hF || h2[3:2] == 2'b11) return 1'b0;
      // Layer II forbids some channel modes at some bitrates.
      if (h1[4:3] == 2'b11 && h1[2:1] == 2'b10 && bad_modes[h3[7:6]]) return 1'b0;
      return h3[1:0] != 2'b10;
    endfunction

    function void close_file(status_e st, logic [28:0] offset);
      out_item_t r;
      r.status       = st;
      r.frame_offset = (st == ST_SYNC) ? offset : '0;
      r.id3_seen     = flags[0];
      r.album_seen   = flags[1];
      expected.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]  cur, b0, b1, b2;
      int unsigned p;
      cur = it.data_byte;
      if (it.start_of_file) begin
        phase    = PH_HEAD;
        pos      = '0;
        recent   = '0;
        tag_size = '0;
        skip_end = '0;
        alb_len  = '0;
        tries    = '0;
        flags    = '0;
        files_started++;
      end
      if (phase == PH_IDLE) return;
      live_bytes++;
      p = pos;
      {b0, b1, b2} = recent;
      case (phase)
        PH_HEAD: begin
          if (p == 3) begin
            // Without an ID3 tag the album probe starts at byte 0.
            if (!(b0 == 8'h49 && b1 == 8'h44 && b2 == 8'h33)) begin
              phase    = PH_PROBE;
              skip_end = '0;
            end
          end else if (p == 9) begin
            tag_size = {b0[6:0], b1[6:0], b2[6:0], cur[6:0]};
            flags[0] = 1'b1;
            skip_end = 29'd10 + tag_size;
            phase    = (tag_size == 0) ? PH_PROBE : PH_SKIP_ID3;
          end
        end
        PH_SKIP_ID3: if (29'(p + 1) == skip_end) phase = PH_PROBE;
        PH_ALBLEN: begin
          if (p == skip_end + 5) begin
            alb_len = {cur, b2};
            if (alb_len < 16'd6) begin
              close_file(ST_ALB_SHORT, '0);
            end else begin
              flags[1] = 1'b1;
              skip_end = skip_end + alb_len;
              phase    = (alb_len == 16'd6) ? PH_SEARCH : PH_SKIP_ALB;
            end
          end
        end
        PH_SKIP_ALB: if (29'(p + 1) == skip_end) phase = PH_SEARCH;
        default: ;
      endcase
      if (phase == PH_PROBE && p == skip_end + 3) begin
        phase = (b0 == 8'h41 && b1 == 8'h69 && b2 == 8'h44 && cur == 8'h01) ?
                PH_ALBLEN : PH_SEARCH;
      end
      if (phase == PH_SEARCH && p >= skip_end + 3) begin
        if (header_valid(b0, b1, b2, cur)) begin
          close_file(ST_SYNC, 29'(p - 3));
        end else begin
          tries = tries + 16'd1;
          if (tries >= limit) close_file(ST_NO_SYNC, '0);
        end
      end
      recent = {recent[15:0], cur};
      pos    = pos + 29'd1;
      if (phase != PH_IDLE && it.end_of_file) close_file(ST_EARLY_END, '0);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result, status %0d offset %0d", got.status,
                         got.frame_offset));
        return;
      end
      want = expected.pop_front();
      results_checked++;
      status_hits[want.status]++;
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, want %0d", results_checked, got.status,
                         want.status));
      if (got.frame_offset !== want.frame_offset)
        report($sformatf("result %0d frame_offset %0d, want %0d", results_checked,
                         got.frame_offset, want.frame_offset));
      if (got.id3_seen !== want.id3_seen)
        report($sformatf("result %0d id3_seen %0b, want %0b", results_checked,
                         got.id3_seen, want.id3_seen));
      if (got.album_seen !== want.album_seen)
        report($sformatf("result %0d album_seen %0b, want %0b", results_checked,
                         got.album_seen, want.album_seen));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_search_limit_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;

  result_scoreboard  sb;
  logic [7:0]        file_bytes[$];
  bit                no_gaps = 1'b0;
  int unsigned       hold_requests = 0;

  mp3_leading_tag_skip_and_sync_find_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_search_limit_i (cfg_search_limit_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_item_i          (in_item_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_item_o         (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] junk_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'hFF;
    if (r < 50) return {3'b111, 5'($urandom)};
    return 8'($urandom);
  endfunction

  // Each call starts at the clock edge that accepted the previous request.
  task automatic send_byte(in_item_t it);
    bit rdy;
    while (!no_gaps && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_byte(it);
  endtask

  task automatic send_file(bit with_eof);
    in_item_t    it;
    int unsigned n;
    n = file_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      it.data_byte     = file_bytes[i];
      it.start_of_file = (i == 0);
      it.end_of_file   = with_eof && (i == n - 1);
      send_byte(it);
    end
  endtask

  task automatic wait_drained(int unsigned extra);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    bit rdy;
    // Let the last byte of a file that gave no result clear the pipeline.
    wait_drained(8);
    cfg_valid_i        <= 1'b1;
    cfg_search_limit_i <= v;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    sb.limit = v;
  endtask

  task automatic push_valid_header();
    logic [7:0] h1, h2, h3;
    do begin
      h1 = {3'b111, 5'($urandom)};
      h2 = 8'($urandom);
      h3 = 8'($urandom);
    end while (!sb.header_valid(8'hFF, h1, h2, h3));
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(h1);
    file_bytes.push_back(h2);
    file_bytes.push_back(h3);
  endtask

  task automatic build_well_formed(int unsigned limit);
    int unsigned tag_len, alb_len, cap;
    file_bytes.delete();
    if ($urandom_range(1) == 1) begin
      tag_len = $urandom_range(20);
      file_bytes.push_back(8'h49);
      file_bytes.push_back(8'h44);
      file_bytes.push_back(8'h33);
      repeat (3) file_bytes.push_back(8'($urandom));
      // Bit 7 of each size byte lies outside the syncsafe value.
      repeat (3) file_bytes.push_back({1'($urandom), 7'd0});
      file_bytes.push_back({1'($urandom), 7'(tag_len)});
      repeat (tag_len) file_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 40) begin
      alb_len = ($urandom_range(99) < 15) ? $urandom_range(5) : $urandom_range(24, 6);
      file_bytes.push_back(8'h41);
      file_bytes.push_back(8'h69);
      file_bytes.push_back(8'h44);
      file_bytes.push_back(($urandom_range(99) < 85) ? 8'h01 : 8'($urandom));
      file_bytes.push_back(8'(alb_len));
      file_bytes.push_back(8'(alb_len >> 8));
      if (alb_len > 6) repeat (alb_len - 6) file_bytes.push_back(8'($urandom));
    end
    cap = (limit < 40) ? limit + 2 : 40;
    repeat ($urandom_range(cap)) file_bytes.push_back(junk_byte());
    push_valid_header();
    repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic run_random_phase(int unsigned limit, int unsigned files);
    int unsigned kind, cut;
    in_item_t    stray;
    for (int unsigned f = 0; f < files; f++) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        build_well_formed(limit);
        if (kind >= 60) begin
          cut = $urandom_range(file_bytes.size(), 1);
          while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        if (kind >= 72) begin
          // Left open on purpose: the next start of file restarts the parse.
          send_file(1'b0);
          build_well_formed(limit);
        end
        send_file(1'b1);
      end else if (kind < 90) begin
        file_bytes.delete();
        repeat ($urandom_range(10, 1)) file_bytes.push_back(junk_byte());
        send_file(1'b1);
      end else begin
        // A long tag or album header that the file ends inside.
        file_bytes.delete();
        if (kind < 95) begin
          file_bytes.push_back(8'h49);
          file_bytes.push_back(8'h44);
          file_bytes.push_back(8'h33);
          repeat (3) file_bytes.push_back(8'($urandom));
          file_bytes.push_back(8'($urandom) | 8'h01);
          repeat (3) file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(8'h41);
        file_bytes.push_back(8'h69);
        file_bytes.push_back(8'h44);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'($urandom));
        file_bytes.push_back(8'($urandom_range(255, 1)));
        repeat ($urandom_range(12)) file_bytes.push_back(8'($urandom));
        send_file(1'b1);
      end
      // Bytes between files belong to no file and should be dropped.
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          stray.data_byte     = 8'($urandom);
          stray.start_of_file = 1'b0;
          stray.end_of_file   = 1'($urandom);
          send_byte(stray);
        end
      end
    end
  endtask

  initial begin : result_sink
    bit          fire;
    out_item_t   got;
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && out_ready_i;
      got  = out_item_o;
      @(posedge clk_i);
      if (fire && rst_ni) sb.check_result(got);
      if (hold_requests > holds_done) begin
        holds_done++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned lim;
    int unsigned base;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ID3 tag, album header of length six, a layer II header with a
    // forbidden bitrate and mode pair, then an acceptable layer II header.
    file_bytes = {8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h41, 8'h69, 8'h44, 8'h01, 8'h06, 8'h00,
                  8'hFF, 8'hFD, 8'h18, 8'h00, 8'hFF, 8'hFD, 8'h48, 8'h00};
    send_file(1'b1);
    // Album length below six.
    file_bytes = {8'h41, 8'h69, 8'h44, 8'h01, 8'h05, 8'h00};
    send_file(1'b1);
    // A limit of zero still allows one candidate.
    write_limit('0);
    file_bytes = {8'h00, 8'h00, 8'h00, 8'h00};
    send_file(1'b1);
    // Largest tag size, with the file ending on the last size byte.
    write_limit('1);
    file_bytes = {8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file(1'b1);

    phase_no = 0;
    base     = sb.live_bytes;
    while (sb.live_bytes - base < RandomBytes || phase_no < MinPhases) begin
      case (phase_no)
        0:       lim = 1;
        1:       lim = 16'hFFFF;
        2:       lim = SearchLimitRst;
        default: lim = ($urandom_range(3) == 0) ? $urandom_range(300, 41) :
                                                  $urandom_range(40, 2);
      endcase
      write_limit(LimitW'(lim));
      no_gaps <= (phase_no == 2);
      if (phase_no == 3) begin
        // Stall the results side for a long stretch while short files keep
        // coming, so the block backs up, then pause until all are out.
        hold_requests <= hold_requests + 1;
        repeat (40) begin
          file_bytes.delete();
          push_valid_header();
          send_file(1'b1);
        end
        wait_drained(1);
      end
      run_random_phase(lim, 6);
      phase_no++;
    end
    wait_drained(10);

    $display("Covered %0d bytes in %0d files over %0d limit settings; %0d results checked.",
             sb.live_bytes, sb.files_started, phase_no + 2, sb.results_checked);
    $display("Results: %0d sync, %0d no sync, %0d early end, %0d short album.",
             sb.status_hits[ST_SYNC], sb.status_hits[ST_NO_SYNC],
             sb.status_hits[ST_EARLY_END], sb.status_hits[ST_ALB_SHORT]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
